@@ src/tctbd_pkg.sv @@
// Package for the two-colour 4x4 tile bitmap decoder.
// Request structs, parse phase codes and the tile job handed to the pixel emitter.
// No dependencies.
package tctbd_pkg;

    // Parse phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PALETTE = 2'd1;
    localparam logic [1:0] PH_TILES   = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // Header byte positions
    localparam logic [2:0] HB_ACROSS_LO = 3'd0;
    localparam logic [2:0] HB_ACROSS_HI = 3'd1;
    localparam logic [2:0] HB_DOWN_LO   = 3'd2;
    localparam logic [2:0] HB_DOWN_HI   = 3'd3;
    localparam logic [2:0] HB_DEPTH_LO  = 3'd4;
    localparam logic [2:0] HB_DEPTH_HI  = 3'd5;

    // Tile byte positions
    localparam logic [2:0] TB_COLOUR1 = 3'd0;
    localparam logic [2:0] TB_COLOUR0 = 3'd1;
    localparam logic [2:0] TB_MAP_LO  = 3'd2;
    localparam logic [2:0] TB_MAP_HI  = 3'd3;

    // Palette component positions
    localparam logic [1:0] PC_BLUE = 2'd2;

    localparam logic [3:0] DEPTH_MAX = 4'd8;

    typedef struct packed {
        logic       start_of_chunk;
        logic [7:0] data_byte;
    } in_req_t;

    typedef struct packed {
        logic [17:0] pixel_x;
        logic [17:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_in_tile;
        logic        last_in_frame;
    } out_req_t;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [15:0] map;
        logic [23:0] rgb1;
        logic [23:0] rgb0;
        logic        last_tile;
    } tile_job_t;

endpackage

@@ src/two_colour_tile_bitmap_decoder_core.sv @@
// Two-colour 4x4 tile bitmap decoder, top level.
// Byte parser, palette memory and tile job slot; instantiates tctbd_pixel_emit.
// Depends on tctbd_pkg.
//
// Usage:
//   src channel: one request per chunk byte (start_of_chunk, data_byte).
//     start_of_chunk restarts parsing at header byte 0. The chunk is a 6-byte
//     header, 3 * 2^depth palette bytes, then 4-byte tiles.
//   pix channel: 16 requests per tile in raster order with coordinates, RGB
//     and last-in-tile / last-in-frame marks.
//   Header and palette bytes are taken one per cycle. In the tile phase the
//   emitter gives one pixel per cycle while the receiver is ready, so tile
//   bytes are paced by the 16 pixels of each tile. The rate is set by the
//   single pixel output register, fed by a one-entry tile job slot.
//   When the emitter is idle, a tile's last byte reaches its first pixel
//   through the palette read with the byte, the job load into the emitter,
//   then the output register.
//   The palette memory is read once per tile at both colour indexes; entries
//   never written since reset read as zero through per-entry valid bits.
//   Reset: parser in the header phase, palette valid bits cleared, no pixel
//   pending. No clearing pass is needed.
//   Receiver stall: the emitter holds its pixel; bytes keep coming in until a
//   tile completes while the job slot is still full, then src_ready drops.
module two_colour_tile_bitmap_decoder_core
    import tctbd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  in_req_t  src_data,
    output logic     pix_valid,
    input  logic     pix_ready,
    output out_req_t pix_data
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    // Parser state
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  pal_comp_reg, pal_comp_next;
    logic [7:0]  pal_entry_reg, pal_entry_next;
    logic [15:0] across_reg, across_next;
    logic [15:0] down_reg, down_next;
    logic [3:0]  depth_reg, depth_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [23:0] partial_reg, partial_next;

    // Tile job slot
    logic        job_valid_reg, job_valid_next;
    logic [15:0] job_col_reg, job_row_reg, job_map_reg;
    logic        job_last_reg;
    logic        job_take;
    tile_job_t   job;

    // Palette memory
    logic [23:0] pal_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] pal_vld_reg;
    logic [23:0] rd1_reg, rd0_reg;
    logic        hit1_reg, hit0_reg;

    logic        src_fire;
    logic [1:0]  eff_phase;
    logic [2:0]  eff_cnt;
    logic [23:0] eff_partial;
    logic        tile_end;
    logic        tile_fire;
    logic [7:0]  b;
    logic [23:0] pal_word;
    logic        pal_we;
    logic [8:0]  last_entry;
    logic [15:0] depth_raw;
    logic [15:0] col_inc, row_inc;
    logic        last_tile;
    logic [7:0]  c1, c0;
    logic        c1_in, c0_in;

    always_comb
    begin
        b           = src_data.data_byte;
        eff_phase   = src_data.start_of_chunk ? PH_HEADER : phase_reg;
        eff_cnt     = src_data.start_of_chunk ? 3'd0 : cnt_reg;
        eff_partial = src_data.start_of_chunk ? 24'd0 : partial_reg;
        tile_end    = (eff_phase == PH_TILES) && (eff_cnt == TB_MAP_HI);
        // only a tile-completing byte waits for the job slot
        src_ready   = !(job_valid_reg && tile_end);
        src_fire    = src_valid && src_ready;
        tile_fire   = src_fire && tile_end;

        pal_word   = {eff_partial[15:0], b};
        last_entry = 9'((9'd1 << depth_reg) - 9'd1);
        depth_raw  = {b, eff_partial[7:0]};
        col_inc    = col_reg + 16'd1;
        row_inc    = row_reg + 16'd1;
        last_tile  = (({1'b0, col_reg} + 17'd1) == {1'b0, across_reg}) &&
                     (({1'b0, row_reg} + 17'd1) == {1'b0, down_reg});
        c1         = eff_partial[7:0];
        c0         = eff_partial[15:8];
        c1_in      = {1'b0, c1} < 9'(PALETTE_ENTRIES);
        c0_in      = {1'b0, c0} < 9'(PALETTE_ENTRIES);
        pal_we     = 1'b0;

        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        pal_comp_next  = pal_comp_reg;
        pal_entry_next = pal_entry_reg;
        across_next    = across_reg;
        down_next      = down_reg;
        depth_next     = depth_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        partial_next   = partial_reg;

        if (src_fire)
        begin
            phase_next   = eff_phase;
            cnt_next     = eff_cnt;
            partial_next = eff_partial;
            case (eff_phase)
                PH_HEADER:
                begin
                    case (eff_cnt)
                        HB_ACROSS_LO: across_next[7:0]  = b;
                        HB_ACROSS_HI: across_next[15:8] = b;
                        HB_DOWN_LO:   down_next[7:0]    = b;
                        HB_DOWN_HI:   down_next[15:8]   = b;
                        HB_DEPTH_LO:  partial_next      = {16'd0, b};
                        default:
                        begin
                            // depth above 8 saturates
                            depth_next = (depth_raw > 16'(DEPTH_MAX)) ?
                                         DEPTH_MAX : depth_raw[3:0];
                        end
                    endcase
                    if (eff_cnt >= HB_DEPTH_HI)
                    begin
                        phase_next     = PH_PALETTE;
                        cnt_next       = 3'd0;
                        partial_next   = 24'd0;
                        pal_comp_next  = 2'd0;
                        pal_entry_next = 8'd0;
                    end
                    else
                    begin
                        cnt_next = eff_cnt + 3'd1;
                    end
                end
                PH_PALETTE:
                begin
                    partial_next = pal_word;
                    if (pal_comp_reg == PC_BLUE)
                    begin
                        pal_we        = {1'b0, pal_entry_reg} < 9'(PALETTE_ENTRIES);
                        pal_comp_next = 2'd0;
                        if ({1'b0, pal_entry_reg} == last_entry)
                        begin
                            cnt_next     = 3'd0;
                            partial_next = 24'd0;
                            col_next     = 16'd0;
                            row_next     = 16'd0;
                            phase_next   = ((across_reg == 16'd0) || (down_reg == 16'd0)) ?
                                           PH_DONE : PH_TILES;
                        end
                        else
                        begin
                            pal_entry_next = pal_entry_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        pal_comp_next = pal_comp_reg + 2'd1;
                    end
                end
                PH_TILES:
                begin
                    if (eff_cnt != TB_MAP_HI)
                    begin
                        case (eff_cnt)
                            TB_COLOUR1: partial_next[7:0]   = b;
                            TB_COLOUR0: partial_next[15:8]  = b;
                            default:    partial_next[23:16] = b;
                        endcase
                        cnt_next = eff_cnt + 3'd1;
                    end
                    else
                    begin
                        cnt_next     = 3'd0;
                        partial_next = 24'd0;
                        if (col_inc >= across_reg)
                        begin
                            col_next = 16'd0;
                            row_next = row_inc;
                            if (row_inc >= down_reg)
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                    end
                end
                default:
                begin
                    // done: bytes ignored until a new chunk
                end
            endcase
        end

        job_valid_next = tile_fire ? 1'b1 : (job_take ? 1'b0 : job_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            cnt_reg       <= 3'd0;
            pal_comp_reg  <= 2'd0;
            pal_entry_reg <= 8'd0;
            across_reg    <= 16'd0;
            down_reg      <= 16'd0;
            depth_reg     <= 4'd0;
            col_reg       <= 16'd0;
            row_reg       <= 16'd0;
            partial_reg   <= 24'd0;
            job_valid_reg <= 1'b0;
            pal_vld_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            pal_comp_reg  <= pal_comp_next;
            pal_entry_reg <= pal_entry_next;
            across_reg    <= across_next;
            down_reg      <= down_next;
            depth_reg     <= depth_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            partial_reg   <= partial_next;
            job_valid_reg <= job_valid_next;
            if (pal_we)
            begin
                pal_vld_reg[pal_entry_reg[AW-1:0]] <= 1'b1;
            end
        end
    end

    // Palette memory: one write port, two registered read ports.
    // Tile reads happen only while no palette byte is taken, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_entry_reg[AW-1:0]] <= pal_word;
        end
        if (tile_fire)
        begin
            rd1_reg      <= pal_mem[c1[AW-1:0]];
            rd0_reg      <= pal_mem[c0[AW-1:0]];
            hit1_reg     <= c1_in && pal_vld_reg[c1[AW-1:0]];
            hit0_reg     <= c0_in && pal_vld_reg[c0[AW-1:0]];
            job_col_reg  <= col_reg;
            job_row_reg  <= row_reg;
            job_map_reg  <= {b, eff_partial[23:16]};
            job_last_reg <= last_tile;
        end
    end

    always_comb
    begin
        job.col       = job_col_reg;
        job.row       = job_row_reg;
        job.map       = job_map_reg;
        job.rgb1      = hit1_reg ? rd1_reg : 24'd0;
        job.rgb0      = hit0_reg ? rd0_reg : 24'd0;
        job.last_tile = job_last_reg;
    end

    tctbd_pixel_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid_reg),
        .job       (job),
        .job_take  (job_take),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data)
    );

    // Checks
    a_job_set: assert property (@(posedge clk) disable iff (!rst_n)
        tile_fire |=> job_valid_reg)
        else $error("tile completed without a pending job");

    a_depth_sat: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("colour depth above saturation limit");

    a_tiles_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TILES) |-> ((across_reg != 16'd0) && (down_reg != 16'd0)))
        else $error("tile phase with an empty frame");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_data.last_in_frame) |-> pix_data.last_in_tile)
        else $error("frame end not on a tile end");

endmodule

@@ src/tctbd_pixel_emit.sv @@
// Pixel emitter: walks one 4x4 tile job into 16 raster-order pixel requests.
// Output register toward the receiver; takes the next job on the last pixel or while idle.
// Depends on tctbd_pkg.
module tctbd_pixel_emit
    import tctbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  tile_job_t job,
    output logic      job_take,
    output logic      pix_valid,
    input  logic      pix_ready,
    output out_req_t  pix_data
);

    logic      cur_busy_reg, cur_busy_next;
    logic [3:0] cur_idx_reg, cur_idx_next;
    tile_job_t cur_reg, cur_next;
    logic      out_valid_reg, out_valid_next;
    out_req_t  out_reg, out_next;

    logic      fire;
    logic      load;
    logic      sel1;
    logic [23:0] rgb;

    always_comb
    begin
        fire = cur_busy_reg && (!out_valid_reg || pix_ready);
        load = (fire && (cur_idx_reg == 4'hF)) || !cur_busy_reg;
        job_take = load && job_valid;

        // map bit 15 belongs to pixel 0
        sel1 = cur_reg.map[~cur_idx_reg];
        rgb  = sel1 ? cur_reg.rgb1 : cur_reg.rgb0;

        out_next.pixel_x       = {cur_reg.col, cur_idx_reg[1:0]};
        out_next.pixel_y       = {cur_reg.row, cur_idx_reg[3:2]};
        out_next.red           = rgb[23:16];
        out_next.green         = rgb[15:8];
        out_next.blue          = rgb[7:0];
        out_next.last_in_tile  = (cur_idx_reg == 4'hF);
        out_next.last_in_frame = (cur_idx_reg == 4'hF) && cur_reg.last_tile;

        out_valid_next = fire ? 1'b1 : (pix_ready ? 1'b0 : out_valid_reg);

        cur_busy_next = cur_busy_reg;
        cur_idx_next  = fire ? cur_idx_reg + 4'd1 : cur_idx_reg;
        cur_next      = cur_reg;
        if (load)
        begin
            cur_busy_next = job_valid;
            if (job_valid)
            begin
                cur_next     = job;
                cur_idx_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_busy_reg  <= 1'b0;
            cur_idx_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_busy_reg  <= cur_busy_next;
            cur_idx_reg   <= cur_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix_data  = out_reg;

endmodule

@@ verif/tb_two_colour_tile_bitmap_decoder_core.sv @@
// Self-checking bench for two_colour_tile_bitmap_decoder_core: chunk byte streams in,
// 4x4 tile pixels out, each pixel compared against an in-bench model of the parser.
// Depends on tctbd_pkg and the core RTL.
module tb_two_colour_tile_bitmap_decoder_core;
    import tctbd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 500;
    localparam int CALM_TAIL    = 80;

    // Parser model plus the queue of pixels it says are still owed.
    class tile_pixel_tracker;
        logic [1:0]  phase;
        logic [9:0]  pos;
        logic [15:0] across;
        logic [15:0] down;
        logic [3:0]  depth;
        logic [15:0] col;
        logic [15:0] row;
        logic [23:0] gathered;
        logic [23:0] palette [256];
        out_req_t    owed_px [$];
        int          errors;

        function void power_on();
            phase    = PH_HEADER;
            pos      = '0;
            across   = '0;
            down     = '0;
            depth    = '0;
            col      = '0;
            row      = '0;
            gathered = '0;
            errors   = 0;
            foreach (palette[k])
                palette[k] = '0;
        endfunction

        function void enter_tiles();
            pos      = '0;
            gathered = '0;
            col      = '0;
            row      = '0;
            phase    = (across == 0 || down == 0) ? PH_DONE : PH_TILES;
        endfunction

        function void note_byte(logic mark, logic [7:0] b);
            logic [15:0] raw_depth;
            logic [9:0]  total;
            logic [15:0] map;
            logic [7:0]  idx;
            logic [23:0] rgb;
            logic        last_tile;
            out_req_t    px;
            if (mark)
            begin
                phase    = PH_HEADER;
                pos      = '0;
                gathered = '0;
            end
            case (phase)
                PH_HEADER:
                begin
                    case (pos)
                        HB_ACROSS_LO: across[7:0]  = b;
                        HB_ACROSS_HI: across[15:8] = b;
                        HB_DOWN_LO:   down[7:0]    = b;
                        HB_DOWN_HI:   down[15:8]   = b;
                        HB_DEPTH_LO:  gathered     = {16'd0, b};
                        default:
                        begin
                            raw_depth = {b, gathered[7:0]};
                            depth = (raw_depth > 16'(DEPTH_MAX)) ? DEPTH_MAX : raw_depth[3:0];
                        end
                    endcase
                    if (pos >= HB_DEPTH_HI)
                    begin
                        phase    = PH_PALETTE;
                        pos      = '0;
                        gathered = '0;
                    end
                    else
                        pos = pos + 1'b1;
                end
                PH_PALETTE:
                begin
                    total    = 10'(3 << depth);
                    gathered = {gathered[15:0], b};
                    if (pos % 3 == PC_BLUE)
                        palette[pos / 3] = gathered;
                    pos = pos + 1'b1;
                    if (pos >= total)
                        enter_tiles();
                end
                PH_TILES:
                begin
                    if (pos < TB_MAP_HI)
                    begin
                        gathered = gathered | (24'(b) << (8 * pos));
                        pos      = pos + 1'b1;
                    end
                    else
                    begin
                        map       = {b, gathered[23:16]};
                        last_tile = (col + 1 == across) && (row + 1 == down);
                        for (int i = 0; i < 16; i++)
                        begin
                            // set map bit picks colour1; bit 15 is the top-left pixel
                            idx              = map[15 - i] ? gathered[7:0] : gathered[15:8];
                            rgb              = palette[idx];
                            px.pixel_x       = {col, 2'b00} + 18'(i % 4);
                            px.pixel_y       = {row, 2'b00} + 18'(i / 4);
                            px.red           = rgb[23:16];
                            px.green         = rgb[15:8];
                            px.blue          = rgb[7:0];
                            px.last_in_tile  = (i == 15);
                            px.last_in_frame = (i == 15) && last_tile;
                            owed_px          = {owed_px, px};
                        end
                        pos      = '0;
                        gathered = '0;
                        col      = col + 1'b1;
                        if (col >= across)
                        begin
                            col = '0;
                            row = row + 1'b1;
                            if (row >= down)
                                phase = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(out_req_t got);
            out_req_t want;
            if (owed_px.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h",
                             got.pixel_x, got.pixel_y, got.red, got.green, got.blue);
                return;
            end
            want = owed_px.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.last_in_tile !== want.last_in_tile ||
                got.last_in_frame !== want.last_in_frame)
            begin
                errors++;
                if (errors <= 10)
                    $display({"pixel mismatch: exp x=%0d y=%0d rgb=%02h%02h%02h lt=%0b lf=%0b,",
                              " got x=%0d y=%0d rgb=%02h%02h%02h lt=%0b lf=%0b"},
                             want.pixel_x, want.pixel_y, want.red, want.green, want.blue,
                             want.last_in_tile, want.last_in_frame,
                             got.pixel_x, got.pixel_y, got.red, got.green, got.blue,
                             got.last_in_tile, got.last_in_frame);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_ready;
    in_req_t  src_data;
    logic     pix_valid;
    logic     pix_ready;
    out_req_t pix_data;

    tile_pixel_tracker pixel_model;
    bit  idle_on;
    bit  hold_req;
    int  bytes_parsed;
    int  cycles;

    two_colour_tile_bitmap_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("two_colour_tile_bitmap_decoder_core regression: fail");
            $finish;
        end
    end

    // Pixel monitor; all values seen here are the pre-edge ones
    always @(posedge clk)
        if (rst_n && pix_valid && pix_ready)
            pixel_model.check_pixel(pix_data);

    // Pixel receiver: random stall bursts, plus one long hold on request
    initial
    begin
        pix_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pix_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pix_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                pix_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                pix_ready <= 1'b1;
            end
            else
                pix_ready <= 1'b1;
        end
    end

    // One byte request; returns at the edge where it was taken
    task automatic send_byte(input logic mark, input logic [7:0] value);
        in_req_t req;
        req.start_of_chunk = mark;
        req.data_byte      = value;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= req;
        do
            @(posedge clk);
        while (!(src_valid && src_ready));
        pixel_model.note_byte(mark, value);
    endtask

    // Builds a chunk with random palette and tiles; cut >= 0 truncates it
    task automatic send_chunk(input logic mark, input logic [15:0] across,
                              input logic [15:0] down, input logic [15:0] depth_field,
                              input int cut);
        logic [7:0] stream [$];
        int         eff;
        longint     tiles;
        stream = {across[7:0], across[15:8], down[7:0], down[15:8],
                  depth_field[7:0], depth_field[15:8]};
        eff = (depth_field > 8) ? 8 : int'(depth_field);
        for (int k = 0; k < 3 * (1 << eff); k++)
            stream = {stream, 8'($urandom)};
        tiles = longint'(across) * longint'(down);
        for (longint t = 0; t < tiles && (cut < 0 || stream.size() < cut); t++)
        begin
            // at least half the indexes land in the freshly loaded palette
            stream = {stream, $urandom_range(0, 1) ? 8'($urandom_range(0, (1 << eff) - 1))
                                                   : 8'($urandom)};
            stream = {stream, $urandom_range(0, 1) ? 8'($urandom_range(0, (1 << eff) - 1))
                                                   : 8'($urandom)};
            stream = {stream, 8'($urandom)};
            stream = {stream, 8'($urandom)};
        end
        if (cut >= 0)
            while (stream.size() > cut)
                void'(stream.pop_back());
        foreach (stream[k])
        begin
            send_byte((k == 0) ? mark : 1'b0, stream[k]);
            bytes_parsed++;
            // no idling on either side in the tail of the run
            if (bytes_parsed >= ITEM_TARGET - CALM_TAIL)
                idle_on = 1'b0;
        end
    endtask

    initial
    begin
        logic [7:0]  first_chunk [$];
        logic [15:0] across;
        logic [15:0] down;
        logic [15:0] depth_field;
        int          kind;
        int          chunk_no;
        int          full_len;
        int          waited;

        pixel_model = new;
        pixel_model.power_on();
        cycles       = 0;
        bytes_parsed = 0;
        hold_req     = 1'b0;
        idle_on      = 1'b1;
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: header straight after reset without the start mark, 1x1 tile,
        // depth 0, one index hitting a never-written palette entry
        first_chunk = {8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                       8'hFF, 8'hFF, 8'hFF,
                       8'h00, 8'hFF, 8'hF0, 8'hA5};
        foreach (first_chunk[k])
        begin
            send_byte(1'b0, first_chunk[k]);
            bytes_parsed++;
        end
        // frame done: stray byte is dropped
        send_byte(1'b0, 8'hFF);
        bytes_parsed++;
        // empty frame: zero tiles across, goes idle after the palette
        send_chunk(1'b1, 16'd0, 16'd5, 16'd0, -1);

        // Random chunks: mostly well formed, some truncated or garbage headers
        chunk_no = 0;
        while (bytes_parsed < ITEM_TARGET)
        begin
            idle_on = (bytes_parsed < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            across  = 16'($urandom_range(1, 4));
            down    = 16'($urandom_range(1, 3));
            depth_field = 16'($urandom_range(0, 2));
            if (chunk_no == 0)
                // oversized depth clamps to 8; cut well inside the 256-entry
                // palette, so no byte may be taken as a tile
                send_chunk(1'b1, 16'd2, 16'd1, 16'd9, 6 + 3 * 40);
            else if (chunk_no == 3)
            begin
                // stall the pixel side while bytes keep coming
                hold_req = 1'b1;
                send_chunk(1'b1, 16'd4, 16'd4, 16'd1, -1);
            end
            else if (kind == 0)
                send_chunk(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                           $urandom_range(1, 40));
            else if (kind == 1)
            begin
                // restart lands somewhere inside a good chunk
                full_len = 6 + 3 * (1 << depth_field) + 4 * across * down;
                send_chunk(1'b1, across, down, depth_field, $urandom_range(1, full_len - 1));
            end
            else if (kind == 2)
                send_chunk(1'b1, $urandom_range(0, 1) ? 16'd0 : across,
                           $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 3)),
                           depth_field, -1);
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    depth_field = 16'($urandom_range(3, 5));
                send_chunk(1'b1, across, down, depth_field, -1);
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 3))
                    begin
                        send_byte(1'b0, 8'($urandom));
                        bytes_parsed++;
                    end
            end
            chunk_no++;
        end
        src_valid <= 1'b0;

        waited = 0;
        while (pixel_model.owed_px.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pixel_model.owed_px.size() != 0)
        begin
            $display("%0d expected pixels never arrived", pixel_model.owed_px.size());
            pixel_model.errors += pixel_model.owed_px.size();
        end

        if (pixel_model.errors == 0)
            $display("two_colour_tile_bitmap_decoder_core regression: pass");
        else
            $display("two_colour_tile_bitmap_decoder_core regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tctbd_pkg.sv
src/tctbd_pixel_emit.sv
src/two_colour_tile_bitmap_decoder_core.sv
verif/tb_two_colour_tile_bitmap_decoder_core.sv
